// ----- sv/cctlux_pkg.sv -----
// ----------------------------------------------------------------------------
// cctlux_pkg
// Types and fixed-point constants for the colour temperature and lux block.
// ----------------------------------------------------------------------------
package cctlux_pkg;

    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic [15:0] red_count;
        logic [15:0] green_count;
        logic [15:0] blue_count;
    } sample_t;

    typedef struct packed {
        logic [15:0] kelvin;
        logic [15:0] lux;
        logic [1:0]  status;
    } result_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SUM_ZERO = 2'd1;
    localparam logic [1:0] ST_DEN_ZERO = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    // rgb to xyz matrix, signed q2.16
    localparam logic signed [17:0] C_XR = -18'sd9360;
    localparam logic signed [17:0] C_XG = 18'sd101531;
    localparam logic signed [17:0] C_XB = -18'sd62679;
    localparam logic signed [17:0] C_YR = -18'sd21277;
    localparam logic signed [17:0] C_YG = 18'sd103440;
    localparam logic signed [17:0] C_YB = -18'sd47966;
    localparam logic signed [17:0] C_ZR = -18'sd44697;
    localparam logic signed [17:0] C_ZG = 18'sd50511;
    localparam logic signed [17:0] C_ZB = 18'sd36918;

    // mccamy epicentre, signed q4.16
    localparam logic signed [19:0] XC0 = 20'sd21758;
    localparam logic signed [19:0] YC0 = 20'sd12177;

    // polynomial constants
    localparam logic [32:0] K_LIN   = 33'd6823;
    localparam logic [21:0] K_LIN3  = 22'd3;
    localparam logic [34:0] K_SQ    = 35'd3525;
    localparam logic [34:0] K_CUBE  = 35'd449;
    localparam logic [44:0] RECIP10 = 45'd6710887;
    localparam int          RECIP_SHIFT = 26;
    localparam logic signed [39:0] CCT_C   = 40'sd361780347;
    localparam logic signed [39:0] CCT_LOW = -40'sd65535;
    localparam logic signed [39:0] CCT_HIGH = 40'sd4294967296;

endpackage

// ----- sv/cctlux_div_cell.sv -----
// ----------------------------------------------------------------------------
// cctlux_div_cell
// One restoring division step: compare, subtract and shift in a quotient bit.
// ----------------------------------------------------------------------------
module cctlux_div_cell #(
    parameter int LANES = 1,
    parameter int W     = 41,
    parameter int QW    = 22,
    parameter int SW    = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         up_valid,
    input  logic [LANES-1:0][W-1:0]      up_rem,
    input  logic [W-1:0]                 up_dvs,
    input  logic [LANES-1:0][QW-1:0]     up_quot,
    input  logic [SW-1:0]                up_side,
    output logic                         dn_valid,
    output logic [LANES-1:0][W-1:0]      dn_rem,
    output logic [W-1:0]                 dn_dvs,
    output logic [LANES-1:0][QW-1:0]     dn_quot,
    output logic [SW-1:0]                dn_side
);

    logic                     valid_reg;
    logic [LANES-1:0][W-1:0]  rem_reg;
    logic [LANES-1:0][W-1:0]  rem_next;
    logic [W-1:0]             dvs_reg;
    logic [LANES-1:0][QW-1:0] quot_reg;
    logic [LANES-1:0][QW-1:0] quot_next;
    logic [SW-1:0]            side_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (up_rem[l] >= up_dvs)
            begin
                rem_next[l]  = up_rem[l] - up_dvs;
                quot_next[l] = {up_quot[l][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[l]  = up_rem[l];
                quot_next[l] = {up_quot[l][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dvs_reg  <= up_dvs >> 1;
            quot_reg <= quot_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_dvs   = dvs_reg;
    assign dn_quot  = quot_reg;
    assign dn_side  = side_reg;

endmodule

// ----- sv/cctlux_div_chain.sv -----
// ----------------------------------------------------------------------------
// cctlux_div_chain
// Row of division cells giving one quotient bit per cell, msb first.
// ----------------------------------------------------------------------------
module cctlux_div_chain #(
    parameter int LANES = 1,
    parameter int W     = 41,
    parameter int QW    = 22,
    parameter int SW    = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     up_valid,
    input  logic [LANES-1:0][W-1:0]  up_rem,
    input  logic [W-1:0]             up_dvs,
    input  logic [SW-1:0]            up_side,
    output logic                     dn_valid,
    output logic [LANES-1:0][QW-1:0] dn_quot,
    output logic [SW-1:0]            dn_side
);

    logic                     valid_w [0:QW];
    logic [LANES-1:0][W-1:0]  rem_w   [0:QW];
    logic [W-1:0]             dvs_w   [0:QW];
    logic [LANES-1:0][QW-1:0] quot_w  [0:QW];
    logic [SW-1:0]            side_w  [0:QW];

    assign valid_w[0] = up_valid;
    assign rem_w[0]   = up_rem;
    assign dvs_w[0]   = up_dvs;
    assign quot_w[0]  = '0;
    assign side_w[0]  = up_side;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        cctlux_div_cell #(
            .LANES (LANES),
            .W     (W),
            .QW    (QW),
            .SW    (SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (valid_w[i]),
            .up_rem   (rem_w[i]),
            .up_dvs   (dvs_w[i]),
            .up_quot  (quot_w[i]),
            .up_side  (side_w[i]),
            .dn_valid (valid_w[i+1]),
            .dn_rem   (rem_w[i+1]),
            .dn_dvs   (dvs_w[i+1]),
            .dn_quot  (quot_w[i+1]),
            .dn_side  (side_w[i+1])
        );
    end

    assign dn_valid = valid_w[QW];
    assign dn_quot  = quot_w[QW];
    assign dn_side  = side_w[QW];

endmodule

// ----- sv/color_temperature_and_lux.sv -----
// ----------------------------------------------------------------------------
// color_temperature_and_lux
// Correlated colour temperature (mccamy) and lux from one raw rgb sample.
// ----------------------------------------------------------------------------
// A request on the sample channel carries red, green and blue counts. Each
// one gives exactly one request on the result channel with kelvin, lux and
// a status code, in order.
// From acceptance to result_valid a sample passes 4 matrix and sum
// stages, an 18-cell divider row for both chromaticities (one quotient bit
// per cell, shared divisor), 3 stages to form the mccamy ratio, a 22-cell
// divider row for n, 5 polynomial stages and the result register.
// One sample per cycle unless stalled; the pipeline holds up to 53 requests.
// The whole pipeline moves as one: while result_valid is high and
// result_stall is high, every stage holds and sample_stall is raised; a
// bubble at the output never blocks the input.
// Reset clears all valid flags, so no result appears until a sample has
// gone through; data registers are not reset.
// ----------------------------------------------------------------------------
module color_temperature_and_lux (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  cctlux_pkg::sample_t sample,
    output logic                result_valid,
    input  logic                result_stall,
    output cctlux_pkg::result_t result
);

    localparam int F   = cctlux_pkg::FRAC_BITS;
    localparam int QX  = F + 2;
    localparam int WX  = 53;
    localparam int QN  = F + 6;
    localparam int WN  = 41;
    localparam int SX  = 22;
    localparam int SN  = 20;

    logic adv;

    // valid flags of the plain stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, result_valid_reg;
    logic c1_valid, c2_valid;

    // stage 1: products
    logic signed [16:0] r_s, g_s, b_s;
    logic signed [34:0] pxr_reg, pxg_reg, pxb_reg;
    logic signed [34:0] pyr_reg, pyg_reg, pyb_reg;
    logic signed [34:0] pzr_reg, pzg_reg, pzb_reg;

    // stage 2: xyz
    logic signed [35:0] x2_reg, y2_reg, z2_reg;

    // stage 3: sum and lux
    logic signed [35:0] x3_reg, y3_reg;
    logic signed [36:0] s3_reg;
    logic [15:0]        lux3_reg;
    logic [15:0]        lux_next;

    // stage 4: magnitudes
    logic [35:0] ax4_reg, ay4_reg, bs4_reg;
    logic        negx4_reg, negy4_reg, zs4_reg;
    logic [15:0] lux4_reg;
    logic [36:0] s_mag;
    logic        ovfx, ovfy;

    logic [1:0][WX-1:0] c1_rem;
    logic [WX-1:0]      c1_dvs;
    logic [SX-1:0]      c1_side_in;
    logic [1:0][QX-1:0] c1_quot;
    logic [SX-1:0]      c1_side;

    // stage 5: chromaticity
    logic signed [18:0] xc5_reg, yc5_reg;
    logic [15:0]        lux5_reg;
    logic               zs5_reg;
    logic [QX-1:0]      capx, capy, mx, my;
    logic               c1_negx, c1_negy, c1_ovfx, c1_ovfy, c1_zs;
    logic [15:0]        c1_lux;

    // stage 6: ratio terms
    logic signed [19:0] num6_reg, den6_reg;
    logic [15:0]        lux6_reg;
    logic               zs6_reg;

    // stage 7: magnitudes for n
    logic [18:0] an7_reg, bd7_reg;
    logic        neg7_reg, dz7_reg, zs7_reg;
    logic [15:0] lux7_reg;
    logic        ovfn;

    logic [0:0][WN-1:0] c2_rem;
    logic [WN-1:0]      c2_dvs;
    logic [SN-1:0]      c2_side_in;
    logic [0:0][QN-1:0] c2_quot;
    logic [SN-1:0]      c2_side;
    logic               c2_neg, c2_ovf, c2_dz, c2_zs;
    logic [15:0]        c2_lux;
    logic [QN-1:0]      limn;

    // stages 8 to 12: polynomial
    logic [19:0] m8_reg, m9_reg;
    logic        neg8_reg, neg9_reg, neg10_reg, neg11_reg;
    logic [1:0]  fl8_reg, fl9_reg, fl10_reg, fl11_reg, fl12_reg;
    logic [15:0] lux8_reg, lux9_reg, lux10_reg, lux11_reg, lux12_reg;
    logic [22:0] n2_9_reg;
    logic [32:0] t1_9_reg, t1_10_reg;
    logic [21:0] m3_9_reg;
    logic [39:0] n2m;
    logic [25:0] n3_10_reg;
    logic [34:0] q2_10_reg, q2_11_reg;
    logic [44:0] f10_reg;
    logic [34:0] p449_11_reg;
    logic [33:0] tm_11_reg;
    logic [42:0] n3p;
    logic signed [39:0] cct12_reg;
    logic signed [39:0] cube_s, lin_s;

    cctlux_pkg::result_t result_reg;
    cctlux_pkg::result_t result_next;

    assign adv          = !result_valid_reg || !result_stall;
    assign sample_stall = !adv;

    // ------------------------------------------------------------------
    // valid pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            v6_reg           <= 1'b0;
            v7_reg           <= 1'b0;
            v8_reg           <= 1'b0;
            v9_reg           <= 1'b0;
            v10_reg          <= 1'b0;
            v11_reg          <= 1'b0;
            v12_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg           <= sample_valid;
            v2_reg           <= v1_reg;
            v3_reg           <= v2_reg;
            v4_reg           <= v3_reg;
            v5_reg           <= c1_valid;
            v6_reg           <= v5_reg;
            v7_reg           <= v6_reg;
            v8_reg           <= c2_valid;
            v9_reg           <= v8_reg;
            v10_reg          <= v9_reg;
            v11_reg          <= v10_reg;
            v12_reg          <= v11_reg;
            result_valid_reg <= v12_reg;
        end
    end

    // ------------------------------------------------------------------
    // matrix
    // ------------------------------------------------------------------
    assign r_s = signed'({1'b0, sample.red_count});
    assign g_s = signed'({1'b0, sample.green_count});
    assign b_s = signed'({1'b0, sample.blue_count});

    always_comb
    begin
        if (y2_reg <= 36'sd0)
            lux_next = 16'd0;
        else if (y2_reg[35:F+16] != '0)
            lux_next = 16'hFFFF;
        else
            lux_next = y2_reg[F+15:F];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxr_reg <= 35'(r_s) * 35'(cctlux_pkg::C_XR);
            pxg_reg <= 35'(g_s) * 35'(cctlux_pkg::C_XG);
            pxb_reg <= 35'(b_s) * 35'(cctlux_pkg::C_XB);
            pyr_reg <= 35'(r_s) * 35'(cctlux_pkg::C_YR);
            pyg_reg <= 35'(g_s) * 35'(cctlux_pkg::C_YG);
            pyb_reg <= 35'(b_s) * 35'(cctlux_pkg::C_YB);
            pzr_reg <= 35'(r_s) * 35'(cctlux_pkg::C_ZR);
            pzg_reg <= 35'(g_s) * 35'(cctlux_pkg::C_ZG);
            pzb_reg <= 35'(b_s) * 35'(cctlux_pkg::C_ZB);

            x2_reg <= 36'(pxr_reg) + 36'(pxg_reg) + 36'(pxb_reg);
            y2_reg <= 36'(pyr_reg) + 36'(pyg_reg) + 36'(pyb_reg);
            z2_reg <= 36'(pzr_reg) + 36'(pzg_reg) + 36'(pzb_reg);

            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            s3_reg   <= 37'(x2_reg) + 37'(y2_reg) + 37'(z2_reg);
            lux3_reg <= lux_next;

            ax4_reg   <= x3_reg[35] ? 36'(-x3_reg) : 36'(x3_reg);
            ay4_reg   <= y3_reg[35] ? 36'(-y3_reg) : 36'(y3_reg);
            bs4_reg   <= s_mag[35:0];
            negx4_reg <= x3_reg[35] != s3_reg[36];
            negy4_reg <= y3_reg[35] != s3_reg[36];
            zs4_reg   <= s3_reg == 37'sd0;
            lux4_reg  <= lux3_reg;
        end
    end

    assign s_mag = s3_reg[36] ? 37'(-s3_reg) : 37'(s3_reg);

    // ------------------------------------------------------------------
    // chromaticity divider, x and y share the divisor
    // ------------------------------------------------------------------
    assign ovfx       = {2'b00, ax4_reg} >= {bs4_reg, 2'b00};
    assign ovfy       = {2'b00, ay4_reg} >= {bs4_reg, 2'b00};
    assign c1_rem[1]  = WX'(ax4_reg) << F;
    assign c1_rem[0]  = WX'(ay4_reg) << F;
    assign c1_dvs     = WX'(bs4_reg) << (QX - 1);
    assign c1_side_in = {lux4_reg, zs4_reg, negx4_reg, negy4_reg, ovfx, ovfy, 1'b0};

    cctlux_div_chain #(
        .LANES (2),
        .W     (WX),
        .QW    (QX),
        .SW    (SX)
    ) u_div_xy (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .up_valid (v4_reg),
        .up_rem   (c1_rem),
        .up_dvs   (c1_dvs),
        .up_side  (c1_side_in),
        .dn_valid (c1_valid),
        .dn_quot  (c1_quot),
        .dn_side  (c1_side)
    );

    assign c1_lux  = c1_side[21:6];
    assign c1_zs   = c1_side[5];
    assign c1_negx = c1_side[4];
    assign c1_negy = c1_side[3];
    assign c1_ovfx = c1_side[2];
    assign c1_ovfy = c1_side[1];

    assign capx = c1_negx ? QX'(1) << (QX - 1) : (QX'(1) << (QX - 1)) - QX'(1);
    assign capy = c1_negy ? QX'(1) << (QX - 1) : (QX'(1) << (QX - 1)) - QX'(1);
    assign mx   = (c1_ovfx || c1_quot[1] > capx) ? capx : c1_quot[1];
    assign my   = (c1_ovfy || c1_quot[0] > capy) ? capy : c1_quot[0];

    // ------------------------------------------------------------------
    // mccamy ratio
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xc5_reg  <= c1_negx ? -signed'({1'b0, mx}) : signed'({1'b0, mx});
            yc5_reg  <= c1_negy ? -signed'({1'b0, my}) : signed'({1'b0, my});
            lux5_reg <= c1_lux;
            zs5_reg  <= c1_zs;

            num6_reg <= 20'(xc5_reg) - cctlux_pkg::XC0;
            den6_reg <= cctlux_pkg::YC0 - 20'(yc5_reg);
            lux6_reg <= lux5_reg;
            zs6_reg  <= zs5_reg;

            an7_reg  <= num6_reg[19] ? 19'(-num6_reg) : 19'(num6_reg);
            bd7_reg  <= den6_reg[19] ? 19'(-den6_reg) : 19'(den6_reg);
            neg7_reg <= num6_reg[19] != den6_reg[19];
            dz7_reg  <= den6_reg == 20'sd0;
            zs7_reg  <= zs6_reg;
            lux7_reg <= lux6_reg;
        end
    end

    assign ovfn       = {6'd0, an7_reg} >= {bd7_reg, 6'd0};
    assign c2_rem[0]  = WN'(an7_reg) << F;
    assign c2_dvs     = WN'(bd7_reg) << (QN - 1);
    assign c2_side_in = {lux7_reg, zs7_reg, dz7_reg, neg7_reg, ovfn};

    cctlux_div_chain #(
        .LANES (1),
        .W     (WN),
        .QW    (QN),
        .SW    (SN)
    ) u_div_n (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .up_valid (v7_reg),
        .up_rem   (c2_rem),
        .up_dvs   (c2_dvs),
        .up_side  (c2_side_in),
        .dn_valid (c2_valid),
        .dn_quot  (c2_quot),
        .dn_side  (c2_side)
    );

    assign c2_lux = c2_side[19:4];
    assign c2_zs  = c2_side[3];
    assign c2_dz  = c2_side[2];
    assign c2_neg = c2_side[1];
    assign c2_ovf = c2_side[0];

    // n clamped to -8 .. 4
    assign limn = c2_neg ? QN'(1) << (F + 3) : QN'(1) << (F + 2);

    // ------------------------------------------------------------------
    // cubic
    // ------------------------------------------------------------------
    assign n2m    = 40'(m8_reg) * 40'(m8_reg);
    assign n3p    = 43'(n2_9_reg) * 43'(m9_reg);
    assign cube_s = neg11_reg ? -signed'(40'(p449_11_reg)) : signed'(40'(p449_11_reg));
    assign lin_s  = neg11_reg ? -signed'(40'(tm_11_reg)) : signed'(40'(tm_11_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m8_reg   <= (c2_ovf || c2_quot[0] > limn) ? 20'(limn) : 20'(c2_quot[0]);
            neg8_reg <= c2_neg;
            fl8_reg  <= {c2_zs, c2_dz};
            lux8_reg <= c2_lux;

            n2_9_reg  <= n2m[38:F];
            t1_9_reg  <= 33'(m8_reg) * cctlux_pkg::K_LIN;
            m3_9_reg  <= 22'(m8_reg) * cctlux_pkg::K_LIN3;
            m9_reg    <= m8_reg;
            neg9_reg  <= neg8_reg;
            fl9_reg   <= fl8_reg;
            lux9_reg  <= lux8_reg;

            n3_10_reg <= n3p[41:F];
            q2_10_reg <= 35'(n2_9_reg) * cctlux_pkg::K_SQ;
            f10_reg   <= 45'(m3_9_reg) * cctlux_pkg::RECIP10;
            t1_10_reg <= t1_9_reg;
            neg10_reg <= neg9_reg;
            fl10_reg  <= fl9_reg;
            lux10_reg <= lux9_reg;

            p449_11_reg <= 35'(n3_10_reg) * cctlux_pkg::K_CUBE;
            tm_11_reg   <= 34'(t1_10_reg)
                         + 34'(f10_reg[44:cctlux_pkg::RECIP_SHIFT]);
            q2_11_reg   <= q2_10_reg;
            neg11_reg   <= neg10_reg;
            fl11_reg    <= fl10_reg;
            lux11_reg   <= lux10_reg;

            cct12_reg <= cube_s + signed'(40'(q2_11_reg)) + lin_s + cctlux_pkg::CCT_C;
            fl12_reg  <= fl11_reg;
            lux12_reg <= lux11_reg;

            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // result
    // ------------------------------------------------------------------
    always_comb
    begin
        result_next.lux = lux12_reg;
        if (fl12_reg[1])
        begin
            result_next.kelvin = 16'd0;
            result_next.status = cctlux_pkg::ST_SUM_ZERO;
        end
        else if (fl12_reg[0])
        begin
            result_next.kelvin = 16'd0;
            result_next.status = cctlux_pkg::ST_DEN_ZERO;
        end
        else if (cct12_reg >= cctlux_pkg::CCT_HIGH)
        begin
            result_next.kelvin = 16'hFFFF;
            result_next.status = cctlux_pkg::ST_SAT;
        end
        else if (cct12_reg < cctlux_pkg::CCT_LOW)
        begin
            result_next.kelvin = 16'd0;
            result_next.status = cctlux_pkg::ST_SAT;
        end
        else if (cct12_reg[39])
        begin
            result_next.kelvin = 16'd0;
            result_next.status = cctlux_pkg::ST_OK;
        end
        else
        begin
            result_next.kelvin = cct12_reg[F+15:F];
            result_next.status = cctlux_pkg::ST_OK;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- tb/color_temperature_and_lux_tb.sv -----
// ----------------------------------------------------------------------------
// color_temperature_and_lux_tb
// Self-checking bench for the colour temperature and lux block: drives raw
// rgb samples in bursts, stalls the result side, and compares every result
// with an in-bench fixed-point computation of lux, kelvin and status.
// ----------------------------------------------------------------------------
module color_temperature_and_lux_tb;

    localparam int  FB        = 16;
    localparam longint LIMIT  = 400000;

    logic                clk;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_stall;
    cctlux_pkg::sample_t sample;
    logic                result_valid;
    logic                result_stall;
    cctlux_pkg::result_t result;

    cctlux_pkg::result_t pending_results[$];
    int      errors;
    longint  cycles;
    logic    stall_mode;

    color_temperature_and_lux DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint round_q(longint num, longint den);
        longint mag;
        longint r;
        begin
            mag = (num < 0) ? -num : num;
            r = (mag * (longint'(1) << FB) + den / 2) / den;
            return (num < 0) ? -r : r;
        end
    endfunction

    function automatic longint sat_div(longint num, longint den, int ib);
        logic   neg;
        longint a;
        longint b;
        longint cap;
        longint q;
        longint rem;
        begin
            neg = (num < 0) != (den < 0);
            a = (num < 0) ? -num : num;
            b = (den < 0) ? -den : den;
            cap = (longint'(1) << (FB + ib - 1)) - (neg ? 0 : 1);
            q = a / b;
            rem = a % b;
            if (q > (cap >>> FB))
                q = cap;
            else
            begin
                for (int i = 0; i < FB; i++)
                begin
                    rem = rem <<< 1;
                    q = q <<< 1;
                    if (rem >= b)
                    begin
                        rem = rem - b;
                        q = q | 1;
                    end
                end
                if (q > cap)
                    q = cap;
            end
            return neg ? -q : q;
        end
    endfunction

    function automatic longint mul_trunc(longint a, longint b);
        logic   neg;
        longint p;
        begin
            neg = (a < 0) != (b < 0);
            p = (((a < 0) ? -a : a) * ((b < 0) ? -b : b)) >>> FB;
            return neg ? -p : p;
        end
    endfunction

    function automatic cctlux_pkg::result_t cct_lux(cctlux_pkg::sample_t s_in);
        longint  r, g, b, x, y, z, s, xc, yc, num, den, n, n2, n3, cct, k;
        cctlux_pkg::result_t res;
        begin
            r = s_in.red_count;
            g = s_in.green_count;
            b = s_in.blue_count;
            res = '0;
            x = round_q(-14282, 100000) * r + round_q(154924, 100000) * g
                + round_q(-95641, 100000) * b;
            y = round_q(-32466, 100000) * r + round_q(157837, 100000) * g
                + round_q(-73191, 100000) * b;
            z = round_q(-68202, 100000) * r + round_q(77073, 100000) * g
                + round_q(56332, 100000) * b;
            if (y <= 0)
                res.lux = 16'd0;
            else if ((y >>> FB) > 65535)
                res.lux = 16'hFFFF;
            else
                res.lux = 16'(y >>> FB);
            s = x + y + z;
            if (s == 0)
                res.status = cctlux_pkg::ST_SUM_ZERO;
            else
            begin
                xc = sat_div(x, s, 2);
                yc = sat_div(y, s, 2);
                num = xc - round_q(3320, 10000);
                den = round_q(1858, 10000) - yc;
                if (den == 0)
                    res.status = cctlux_pkg::ST_DEN_ZERO;
                else
                begin
                    n = sat_div(num, den, 6);
                    if (n > 4 * (longint'(1) << FB))
                        n = 4 * (longint'(1) << FB);
                    if (n < -8 * (longint'(1) << FB))
                        n = -8 * (longint'(1) << FB);
                    n2 = mul_trunc(n, n);
                    n3 = mul_trunc(n2, n);
                    cct = 449 * n3 + 3525 * n2 + (68233 * n) / 10 + round_q(552033, 100);
                    k = (cct >= 0) ? (cct >>> FB) : -((-cct) >>> FB);
                    if (k < 0)
                    begin
                        res.kelvin = 16'd0;
                        res.status = cctlux_pkg::ST_SAT;
                    end
                    else if (k > 65535)
                    begin
                        res.kelvin = 16'hFFFF;
                        res.status = cctlux_pkg::ST_SAT;
                    end
                    else
                    begin
                        res.kelvin = 16'(k);
                        res.status = cctlux_pkg::ST_OK;
                    end
                end
            end
            return res;
        end
    endfunction

    // sends one request, waiting out the stall
    task automatic send_sample(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
        cctlux_pkg::sample_t item;
        begin
            item.red_count = red;
            item.green_count = green;
            item.blue_count = blue;
            sample_valid <= 1'b1;
            sample <= item;
            @(posedge clk);
            while (sample_stall)
                @(posedge clk);
            pending_results.push_back(cct_lux(item));
        end
    endtask

    task automatic idle_gap(int n);
        begin
            if (n > 0)
            begin
                sample_valid <= 1'b0;
                sample <= cctlux_pkg::sample_t'(48'({$urandom, $urandom}));
                repeat (n) @(posedge clk);
            end
        end
    endtask

    task automatic test_corners();
        logic [15:0] v[4];
        begin
            v[0] = 16'd0;
            v[1] = 16'd1;
            v[2] = 16'h8000;
            v[3] = 16'hFFFF;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j += 3)
                    send_sample(v[i], v[j], v[(i + j) % 4]);
            send_sample(16'd0, 16'd0, 16'd0);
            send_sample(16'd100, 16'd3000, 16'd200);
            send_sample(16'd5000, 16'd100, 16'd100);
            send_sample(16'd100, 16'd100, 16'd5000);
            send_sample(16'd1000, 16'd1000, 16'd1000);
            send_sample(16'd0, 16'hFFFF, 16'd0);
            idle_gap(1);
        end
    endtask

    task automatic test_random(int count);
        int burst;
        int hi;
        logic [15:0] r, g, b;
        begin
            while (count > 0)
            begin
                burst = $urandom_range(1, 40);
                for (int i = 0; i < burst && count > 0; i++)
                begin
                    hi = $urandom_range(0, 3);
                    if (hi == 0)
                    begin
                        r = 16'($urandom);
                        g = 16'($urandom);
                        b = 16'($urandom);
                    end
                    else
                    begin
                        // plausible light: green dominant, scaled range
                        g = 16'($urandom_range(0, 65535 >> $urandom_range(0, 8)));
                        r = 16'($urandom_range(0, g));
                        b = 16'($urandom_range(0, g));
                    end
                    send_sample(r, g, b);
                    count--;
                end
                idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
            end
            idle_gap(1);
        end
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_mode <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                stall_mode <= ~stall_mode;
            result_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing outstanding");
                errors++;
            end
            else
            begin
                cctlux_pkg::result_t exp_r;
                exp_r = pending_results.pop_front();
                if (result.kelvin !== exp_r.kelvin)
                begin
                    $error("kelvin expected %0d actual %0d", exp_r.kelvin, result.kelvin);
                    errors++;
                end
                if (result.lux !== exp_r.lux)
                begin
                    $error("lux expected %0d actual %0d", exp_r.lux, result.lux);
                    errors++;
                end
                if (result.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, result.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random(800);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/cctlux_pkg.sv
sv/cctlux_div_cell.sv
sv/cctlux_div_chain.sv
sv/color_temperature_and_lux.sv
tb/color_temperature_and_lux_tb.sv
